FILE: rtl/skts_pkg.sv
// shared types and codes for the sorted key table
`timescale 1ns / 1ps

package skts_pkg;

  // command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_ORDER     = 2'd3;

  // input beat
  typedef struct packed {
    logic        [1:0]  command;
    logic signed [31:0] key;
    logic        [31:0] info;
  } skts_in_t;

  // result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  index;
    logic [31:0] info_out;
    logic [6:0]  count;
  } skts_out_t;

  // token walking down the row of cells
  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [31:0] key;
    logic        [31:0] info;
    logic               found;
    logic               order_bad;
    logic        [31:0] hit_info;
  } skts_tok_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_WAIT
  } skts_state_t;

endpackage

FILE: rtl/skts_cell.sv
// one table entry with its slot of the walking token pipeline
`timescale 1ns / 1ps

module skts_cell #(
  parameter int IDXW     = 6,
  parameter int CNTW     = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CNTW-1:0]     count,
  input  logic                tok_vld_i,
  input  skts_pkg::skts_tok_t tok_i,
  input  logic [IDXW-1:0]     idx_i,
  input  logic signed [31:0]  nb_key,
  input  logic [31:0]         nb_info,
  output logic                tok_vld_o,
  output skts_pkg::skts_tok_t tok_o,
  output logic [IDXW-1:0]     idx_o,
  output logic signed [31:0]  key_o,
  output logic [31:0]         info_o
);

  localparam logic [CNTW-1:0] MY_POS   = CNTW'(CELL_IDX);
  localparam logic [CNTW-1:0] NEXT_POS = CNTW'(CELL_IDX + 1);
  localparam logic [IDXW-1:0] MY_IDX   = IDXW'(CELL_IDX);

  logic signed [31:0]  key_r, key_nxt;
  logic [31:0]         info_r, info_nxt;
  logic                tok_vld_r;
  skts_pkg::skts_tok_t tok_r, tok_nxt;
  logic [IDXW-1:0]     idx_r, idx_nxt;
  logic                live;
  logic                lookup;
  logic                match;
  logic                hit;

  assign live   = (MY_POS < count);
  assign lookup = (tok_i.cmd == skts_pkg::CMD_SEARCH) || (tok_i.cmd == skts_pkg::CMD_ERASE);
  assign match  = tok_vld_i && live && lookup && (tok_i.key == key_r);
  assign hit    = tok_i.found || match;

  // token update and entry write
  always_comb begin
    tok_nxt  = tok_i;
    idx_nxt  = idx_i;
    key_nxt  = key_r;
    info_nxt = info_r;
    // first hit records position and info word
    if (match && !tok_i.found) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.hit_info = info_r;
      idx_nxt          = MY_IDX;
    end
    // last held entry checks the order of an appended key
    if (tok_vld_i && tok_i.cmd == skts_pkg::CMD_APPEND && NEXT_POS == count &&
        !(tok_i.key > key_r)) begin
      tok_nxt.order_bad = 1'b1;
    end
    // erase closes the gap: take the neighbour's entry
    if (tok_vld_i && tok_i.cmd == skts_pkg::CMD_ERASE && hit) begin
      key_nxt  = nb_key;
      info_nxt = nb_info;
    end
    // append writes the first free slot
    if (tok_vld_i && tok_i.cmd == skts_pkg::CMD_APPEND && MY_POS == count &&
        !tok_i.order_bad) begin
      key_nxt  = tok_i.key;
      info_nxt = tok_i.info;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    info_r <= info_nxt;
    tok_r  <= tok_nxt;
    idx_r  <= idx_nxt;
  end

  // token valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_i;
    end
  end

  assign tok_vld_o = tok_vld_r;
  assign tok_o     = tok_r;
  assign idx_o     = idx_r;
  assign key_o     = key_r;
  assign info_o    = info_r;

endmodule

FILE: rtl/sorted_key_table_search_erase_core.sv
// sorted key table: row of entry cells with a walking command token
// the token is registered in each cell in turn; the result beat is registered after the last cell
// no new item is taken until the result beat of the item before is issued; the token steps one cell a cycle
// erase shifts each later entry down as the token passes it
// reset: entry count cleared, token and result valids cleared; entry contents left as they are
`timescale 1ns / 1ps

module sorted_key_table_search_erase_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  skts_pkg::skts_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output skts_pkg::skts_out_t out_data
);

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(TABLE_DEPTH);

  skts_pkg::skts_state_t state_r, state_nxt;
  logic [CNTW-1:0]       count_r, count_nxt;
  logic                  out_vld_r, out_vld_nxt;
  skts_pkg::skts_out_t   out_data_r, out_data_nxt;
  skts_pkg::skts_out_t   pend_r, pend_nxt;
  skts_pkg::skts_out_t   res;
  logic [CNTW-1:0]       res_cnt;

  logic                tok_vld [0:TABLE_DEPTH];
  skts_pkg::skts_tok_t tok     [0:TABLE_DEPTH];
  logic [IDXW-1:0]     idx     [0:TABLE_DEPTH];
  logic signed [31:0]  ent_key [0:TABLE_DEPTH-1];
  logic [31:0]         ent_info[0:TABLE_DEPTH-1];

  // token injection at the head of the row
  assign tok_vld[0] = in_valid && !in_stall;
  assign tok[0]     = '{cmd: in_data.command, key: in_data.key, info: in_data.info,
                        found: 1'b0, order_bad: 1'b0, hit_info: '0};
  assign idx[0]     = '0;

  // row of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic signed [31:0] nb_key;
    logic [31:0]        nb_info;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nb_key  = ent_key[i];
      assign nb_info = ent_info[i];
    end else begin : g_body
      assign nb_key  = ent_key[i+1];
      assign nb_info = ent_info[i+1];
    end
    skts_cell #(
      .IDXW     (IDXW),
      .CNTW     (CNTW),
      .CELL_IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .count     (count_r),
      .tok_vld_i (tok_vld[i]),
      .tok_i     (tok[i]),
      .idx_i     (idx[i]),
      .nb_key    (nb_key),
      .nb_info   (nb_info),
      .tok_vld_o (tok_vld[i+1]),
      .tok_o     (tok[i+1]),
      .idx_o     (idx[i+1]),
      .key_o     (ent_key[i]),
      .info_o    (ent_info[i])
    );
  end

  // result from the token leaving the row
  always_comb begin
    res     = '0;
    res_cnt = count_r;
    case (tok[TABLE_DEPTH].cmd)
      skts_pkg::CMD_APPEND: begin
        if (count_r == FULL_CNT) begin
          res.status = skts_pkg::ST_FULL;
        end else if (tok[TABLE_DEPTH].order_bad) begin
          res.status = skts_pkg::ST_ORDER;
        end else begin
          res.status = skts_pkg::ST_OK;
          res_cnt    = count_r + 1'b1;
        end
      end
      skts_pkg::CMD_SEARCH, skts_pkg::CMD_ERASE: begin
        if (tok[TABLE_DEPTH].found) begin
          res.status   = skts_pkg::ST_OK;
          res.index    = 6'(idx[TABLE_DEPTH]);
          res.info_out = tok[TABLE_DEPTH].hit_info;
          if (tok[TABLE_DEPTH].cmd == skts_pkg::CMD_ERASE) begin
            res_cnt = count_r - 1'b1;
          end
        end else begin
          res.status = skts_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        res.status = skts_pkg::ST_OK;
      end
    endcase
    res.count = 7'(res_cnt);
  end

  // controller next state and outputs
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_data_nxt = out_data_r;
    pend_nxt     = pend_r;
    case (state_r)
      skts_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = skts_pkg::S_WALK;
        end
      end
      skts_pkg::S_WALK: begin
        if (tok_vld[TABLE_DEPTH]) begin
          count_nxt = res_cnt;
          if (!out_vld_r || !out_stall) begin
            out_vld_nxt  = 1'b1;
            out_data_nxt = res;
            state_nxt    = skts_pkg::S_IDLE;
          end else begin
            pend_nxt  = res;
            state_nxt = skts_pkg::S_WAIT;
          end
        end
      end
      skts_pkg::S_WAIT: begin
        if (!out_stall) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = pend_r;
          state_nxt    = skts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = skts_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= skts_pkg::S_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pend_r     <= pend_nxt;
  end

  assign in_stall  = (state_r != skts_pkg::S_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/skts_checker.sv
// port-level checks for the sorted key table, bound to the top level
`timescale 1ns / 1ps

module skts_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input skts_pkg::skts_out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // one item at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // failing statuses carry no position or info word
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != skts_pkg::ST_OK) |->
      (out_data.index == 6'd0) && (out_data.info_out == 32'd0))
    else $error("failed item reports index or info");

  // table full only when the count is at depth
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == skts_pkg::ST_FULL) |->
      (out_data.count == 7'(TABLE_DEPTH)))
    else $error("full reported below depth");

  // a new result only follows a busy cycle
  a_res_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in flight");

endmodule

bind sorted_key_table_search_erase_core skts_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_skts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/sv/skts_table_checker.sv
// checker for the sorted key table: watches both channels, predicts each result beat and compares
`timescale 1ns / 1ps

module skts_table_checker #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  skts_pkg::skts_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  skts_pkg::skts_out_t out_data,
  output int                  errors,
  output int                  pending
);

  // shadow copy of the table
  logic signed [31:0] key_tab [DEPTH];
  logic        [31:0] info_tab[DEPTH];
  int                 fill;

  skts_pkg::skts_out_t due_results[$];
  int                  fail_cnt;

  assign errors = fail_cnt;

  // apply one command to the shadow table and return the result it should give
  function automatic skts_pkg::skts_out_t apply_command(skts_pkg::skts_in_t beat);
    skts_pkg::skts_out_t res;
    int                  pos;
    int                  i;
    res = '0;
    res.status = skts_pkg::ST_OK;
    pos = -1;
    case (beat.command)
      skts_pkg::CMD_APPEND: begin
        if (fill >= DEPTH) begin
          res.status = skts_pkg::ST_FULL;
        end else if (fill > 0 && beat.key <= key_tab[fill-1]) begin
          // duplicates are refused as well
          res.status = skts_pkg::ST_ORDER;
        end else begin
          key_tab[fill]  = beat.key;
          info_tab[fill] = beat.info;
          fill++;
        end
      end
      skts_pkg::CMD_SEARCH, skts_pkg::CMD_ERASE: begin
        // keys are unique, so a plain scan finds the same slot as a binary search
        for (i = 0; i < fill; i++) begin
          if (key_tab[i] == beat.key) pos = i;
        end
        if (pos < 0) begin
          res.status = skts_pkg::ST_NOT_FOUND;
        end else begin
          res.index    = pos[5:0];
          res.info_out = info_tab[pos];
          if (beat.command == skts_pkg::CMD_ERASE) begin
            // close the gap
            for (i = pos; i < fill - 1; i++) begin
              key_tab[i]  = key_tab[i+1];
              info_tab[i] = info_tab[i+1];
            end
            fill--;
          end
        end
      end
      default: begin
        // spare command code leaves the table alone
      end
    endcase
    res.count = fill[6:0];
    return res;
  endfunction

  // predict on accepted input beats, compare on accepted result beats
  always @(posedge clk) begin
    skts_pkg::skts_out_t want;
    if (!rst_n) begin
      fill = 0;
      due_results.delete();
      fail_cnt = 0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(apply_command(in_data));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d index %0d count %0d",
                 out_data.status, out_data.index, out_data.count);
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
            fail_cnt++;
          end
          if (out_data.index !== want.index) begin
            $error("index mismatch: expected %0d, actual %0d", want.index, out_data.index);
            fail_cnt++;
          end
          if (out_data.info_out !== want.info_out) begin
            $error("info_out mismatch: expected %h, actual %h", want.info_out,
                   out_data.info_out);
            fail_cnt++;
          end
          if (out_data.count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, out_data.count);
            fail_cnt++;
          end
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

FILE: tb/sv/tb.sv
// testbench top for the sorted key table: stimulus, channel pacing and verdict
`timescale 1ns / 1ps

module tb;

  localparam int                 DEPTH      = 64;
  localparam int                 ITEM_COUNT = 1850;
  localparam logic [1:0]         CMD_SPARE  = 2'd3;
  localparam logic signed [31:0] KEY_MIN    = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX    = 32'sh7fff_ffff;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  skts_pkg::skts_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  skts_pkg::skts_out_t out_data;
  int                  errors;
  int                  pending;
  int                  sent;
  logic                calm;

  // keys that may sit in the table, so searches and erases mostly hit
  logic signed [31:0] key_pool[$];
  longint             tail_key;
  bit                 have_tail;

  sorted_key_table_search_erase_core #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  skts_table_checker #(.DEPTH(DEPTH)) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(0, 99) < 37);
  end

  // one input beat, with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] key,
                           input logic [31:0] info);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, key: key, info: info};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // hold off until every result beat is back
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // pick a key from the pool, or a random one when the pool is empty
  function automatic logic signed [31:0] pool_key(bit remove);
    int idx;
    logic signed [31:0] k;
    if (key_pool.size() == 0) return $urandom();
    idx = $urandom_range(0, key_pool.size() - 1);
    k = key_pool[idx];
    if (remove) key_pool.delete(idx);
    return k;
  endfunction

  // append a key above the current tail, or the tail again once the key range runs out
  task automatic append_next();
    longint nxt;
    longint step;
    step = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 1 << 24);
    if (!have_tail) nxt = longint'(KEY_MIN) + longint'($urandom_range(0, 32'h8000_0000));
    else nxt = tail_key + step;
    if (nxt > longint'(KEY_MAX)) nxt = tail_key;
    tail_key  = nxt;
    have_tail = 1'b1;
    key_pool.push_back(nxt[31:0]);
    send_item(skts_pkg::CMD_APPEND, nxt[31:0], $urandom());
  endtask

  // append a duplicate of the tail or a wild key; mostly refused
  task automatic append_noise();
    logic signed [31:0] k;
    if (have_tail && $urandom_range(0, 1) == 0) k = tail_key[31:0];
    else k = $urandom();
    if (!have_tail || longint'(k) > tail_key) tail_key = longint'(k);
    have_tail = 1'b1;
    key_pool.push_back(k);
    send_item(skts_pkg::CMD_APPEND, k, $urandom());
  endtask

  // build the table up, then erase it all again
  task automatic run_round(input int asc_target);
    int asc;
    int r;
    asc = 0;
    while (asc < asc_target) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        append_next();
        asc++;
      end else if (r < 70) append_noise();
      else if (r < 85) send_item(skts_pkg::CMD_SEARCH, pool_key(1'b0), $urandom());
      else if (r < 95) send_item(skts_pkg::CMD_ERASE, pool_key(1'b1), $urandom());
      else send_item(CMD_SPARE, $urandom(), $urandom());
    end
    while (key_pool.size() > 0) begin
      r = $urandom_range(0, 99);
      if (r < 65) send_item(skts_pkg::CMD_ERASE, pool_key(1'b1), $urandom());
      else if (r < 85) send_item(skts_pkg::CMD_SEARCH, pool_key(1'b0), $urandom());
      else if (r < 92) send_item(skts_pkg::CMD_SEARCH, $urandom(), $urandom());
      else if (r < 96) send_item(skts_pkg::CMD_ERASE, $urandom(), $urandom());
      else send_item(CMD_SPARE, $urandom(), $urandom());
    end
    have_tail = 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    int round;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    calm      <= 1'b0;
    sent      = 0;
    have_tail = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, key extremes, ordering refusals, erase at each end
    send_item(skts_pkg::CMD_SEARCH, 32'sd0, 32'h0);
    send_item(skts_pkg::CMD_ERASE, KEY_MIN, 32'hffff_ffff);
    send_item(CMD_SPARE, KEY_MAX, 32'hffff_ffff);
    send_item(skts_pkg::CMD_APPEND, KEY_MIN, 32'h0000_0000);
    send_item(skts_pkg::CMD_APPEND, -32'sd1, 32'hffff_ffff);
    send_item(skts_pkg::CMD_APPEND, 32'sd0, 32'ha5a5_a5a5);
    send_item(skts_pkg::CMD_APPEND, KEY_MAX, 32'h5a5a_5a5a);
    send_item(skts_pkg::CMD_APPEND, KEY_MAX, 32'h1234_5678);
    send_item(skts_pkg::CMD_APPEND, 32'sd5, 32'h8765_4321);
    send_item(skts_pkg::CMD_SEARCH, KEY_MIN, $urandom());
    send_item(skts_pkg::CMD_SEARCH, KEY_MAX, $urandom());
    send_item(skts_pkg::CMD_SEARCH, 32'sd0, $urandom());
    send_item(skts_pkg::CMD_SEARCH, 32'sd7, $urandom());
    send_item(CMD_SPARE, $urandom(), $urandom());
    send_item(skts_pkg::CMD_ERASE, -32'sd1, $urandom());
    send_item(skts_pkg::CMD_SEARCH, 32'sd0, $urandom());
    send_item(skts_pkg::CMD_SEARCH, KEY_MAX, $urandom());
    send_item(skts_pkg::CMD_ERASE, KEY_MAX, $urandom());
    send_item(skts_pkg::CMD_ERASE, KEY_MIN, $urandom());
    send_item(skts_pkg::CMD_ERASE, -32'sd1, $urandom());
    send_item(skts_pkg::CMD_ERASE, 32'sd0, $urandom());
    send_item(skts_pkg::CMD_APPEND, KEY_MAX, 32'hdead_beef);
    send_item(skts_pkg::CMD_SEARCH, KEY_MAX, $urandom());
    send_item(skts_pkg::CMD_ERASE, KEY_MAX, $urandom());
    wait_quiet();

    // random rounds: every other one fills the table past full
    round = 0;
    while (sent < ITEM_COUNT) begin
      calm <= (round == 2);
      if (round % 2 == 0) run_round(85);
      else run_round($urandom_range(2, 40));
      wait_quiet();
      round++;
    end
    calm <= 1'b0;

    // let any stray result beat show up
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (errors == 0 && pending == 0) $display("sorted_key_table_search_erase_core test passed");
    else $display("sorted_key_table_search_erase_core test failed");
    $finish;
  end

  // watchdog: several times the slowest correct run
  initial begin
    #10_000_000;
    $display("sorted_key_table_search_erase_core test failed");
    $finish;
  end

endmodule
